// ----- hdl/bctd_pkg.sv -----
// shared types, constants and palette helpers for the block decoder
package bctd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FORMAT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_BC1  = 2'd0,
    FMT_BC3  = 2'd1,
    FMT_BC5  = 2'd2,
    FMT_NONE = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [11:0] block_col;
    logic [11:0] block_row;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } in_word_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } out_word_t;

  // one classified block waiting for the back end
  typedef struct packed {
    fmt_e        fmt;
    logic [15:0] mask;
    logic [13:0] base_x;
    logic [13:0] base_y;
    logic [63:0] lo;
    logic [63:0] hi;
  } job_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd527 + 16'd23;
    return p[13:6];
  endfunction

  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd259 + 16'd33;
    return p[13:6];
  endfunction

  // x/3 for x < 768 via reciprocal
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd2731;
    return p[20:13];
  endfunction

  // x/7 for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd9363;
    return p[23:16];
  endfunction

  // x/5 for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd13108;
    return p[23:16];
  endfunction

  function automatic logic [7:0] chan_entry(input logic [7:0] e0, input logic [7:0] e1,
                                            input logic [2:0] i);
    logic [10:0] a;
    logic [10:0] b;
    logic [7:0]  r;
    a = 11'(e0);
    b = 11'(e1);
    r = 8'd0;
    if (i == 3'd0) r = e0;
    else if (i == 3'd1) r = e1;
    else if (e0 > e1) begin
      r = div7(11'(4'd8 - 4'(i)) * a + 11'(4'(i) - 4'd1) * b);
    end else if (i == 3'd6) r = 8'd0;
    else if (i == 3'd7) r = 8'd255;
    else begin
      r = div5(11'(4'd6 - 4'(i)) * a + 11'(4'(i) - 4'd1) * b);
    end
    return r;
  endfunction

endpackage

// ----- hdl/bctd_front.sv -----
// front end: clips the block against the image and builds the texel mask
module bctd_front #(
  parameter int unsigned MaxImageSize = 16384
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bctd_pkg::in_word_t in_i,
  input  logic [14:0]       width_i,
  input  logic [14:0]       height_i,
  input  bctd_pkg::fmt_e    fmt_i,
  input  bctd_pkg::q_stat_t stat_i,
  output logic              busy_o,
  output logic              push_o,
  output bctd_pkg::job_t    job_o
);
  import bctd_pkg::*;

  localparam logic [16:0] MaxSz = 17'(MaxImageSize);

  logic [16:0] w_sat, h_sat;
  logic [13:0] bx, by;
  logic [15:0] mask;

  assign busy_o = stat_i.full;
  assign bx = {in_i.block_col, 2'b00};
  assign by = {in_i.block_row, 2'b00};

  always_comb begin
    w_sat = (17'(width_i) > MaxSz) ? MaxSz : 17'(width_i);
    h_sat = (17'(height_i) > MaxSz) ? MaxSz : 17'(height_i);
    for (int t = 0; t < 16; t++) begin
      mask[t] = (17'(bx) + 17'(t % 4) < w_sat) && (17'(by) + 17'(t / 4) < h_sat);
    end
  end

  always_comb begin
    job_o.fmt    = fmt_i;
    job_o.mask   = mask;
    job_o.base_x = bx;
    job_o.base_y = by;
    job_o.lo     = in_i.block_low;
    job_o.hi     = in_i.block_high;
    push_o = start_i && !stat_i.full && (mask != 16'd0) && (fmt_i != FMT_NONE);
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.full |-> !push_o) else $error("push into full queue");
  a_mask_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> job_o.mask[0]) else $error("first texel clipped but block pushed");
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o == stat_i.full) else $error("busy mismatch");
`endif

endmodule

// ----- hdl/bctd_queue.sv -----
// two-entry queue between front and back end
module bctd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bctd_pkg::job_t    job_i,
  input  logic              pop_i,
  output bctd_pkg::job_t    job_o,
  output bctd_pkg::q_stat_t stat_o
);
  import bctd_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign job_o = mem_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

`ifndef NO_ASSERTIONS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push_i) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop_i) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ----- hdl/bctd_isqrt.sv -----
// pipelined integer square root, two result bits per stage
module bctd_isqrt (
  input  logic        clk_i,
  input  logic [15:0] v_i,
  output logic [7:0]  r_o
);
  logic [15:0] rem_q [1:4];
  logic [7:0]  res_q [1:4];

  for (genvar s = 0; s < 4; s++) begin : g_st
    logic [15:0] rem_in;
    logic [7:0]  res_in;
    logic [15:0] rem_d;
    logic [7:0]  res_d;
    if (s == 0) begin : g_first
      assign rem_in = v_i;
      assign res_in = 8'd0;
    end else begin : g_next
      assign rem_in = rem_q[s];
      assign res_in = res_q[s];
    end
    always_comb begin
      logic [17:0] rm;
      logic [17:0] tr;
      rem_d = rem_in;
      res_d = res_in;
      for (int k = 0; k < 2; k++) begin
        rm = 18'(rem_d);
        // trial (4 * root + 1) at the weight of the bit being decided
        tr = 18'({res_d, 2'b01}) << (14 - 4*s - 2*k);
        res_d = res_d << 1;
        if (rm >= tr) begin
          rem_d = 16'(rm - tr);
          res_d = res_d | 8'd1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      res_q[s+1] <= res_d;
    end
  end

  assign r_o = res_q[4];

endmodule

// ----- hdl/bctd_back.sv -----
// back end: walks the texel mask and decodes one pixel per cycle while a block is queued
module bctd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bctd_pkg::job_t    job_i,
  input  bctd_pkg::q_stat_t stat_i,
  output logic              pop_o,
  output logic              done_o,
  output bctd_pkg::out_word_t word_o
);
  import bctd_pkg::*;

  localparam int unsigned Lat = 6;

  logic [15:0] left_q;
  logic        act_q;
  logic [3:0]  t;
  logic [15:0] cur, rest;

  // pick lowest remaining texel
  always_comb begin
    cur  = act_q ? left_q : job_i.mask;
    t    = 4'd0;
    for (int k = 15; k >= 0; k--) if (cur[k]) t = 4'(k);
    rest = cur & ~(16'd1 << t);
  end

  logic go;
  assign go    = act_q || !stat_i.empty;
  assign pop_o = go && (rest == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      left_q <= 16'd0;
    end else if (go) begin
      act_q  <= rest != 16'd0;
      left_q <= rest;
    end
  end

  // stage 1: palette lookup
  logic [7:0] c0r, c0g, c0b, c1r, c1g, c1b;
  logic [63:0] cblk;
  logic [1:0] ci;
  logic [2:0] ai, gi;
  logic [7:0] r1, g1, b1, a1, ch_a, ch_g;
  logic       transp;
  logic [7:0] vr [3];
  logic [7:0] vc0 [3];
  logic [7:0] vc1 [3];

  always_comb begin
    cblk = (job_i.fmt == FMT_BC1) ? job_i.lo : job_i.hi;
    c0r = exp5(cblk[15:11]); c0g = exp6(cblk[10:5]); c0b = exp5(cblk[4:0]);
    c1r = exp5(cblk[31:27]); c1g = exp6(cblk[26:21]); c1b = exp5(cblk[20:16]);
    vc0[0] = c0r; vc0[1] = c0g; vc0[2] = c0b;
    vc1[0] = c1r; vc1[1] = c1g; vc1[2] = c1b;
    ci = cblk[32 + 2*t +: 2];
    ai = job_i.lo[16 + 3*t +: 3];
    gi = job_i.hi[16 + 3*t +: 3];
    transp = (job_i.fmt == FMT_BC1) && (cblk[15:0] <= cblk[31:16]);
    for (int k = 0; k < 3; k++) begin
      case (ci)
        2'd0: vr[k] = vc0[k];
        2'd1: vr[k] = vc1[k];
        2'd2: vr[k] = transp ? 8'((9'(vc0[k]) + 9'(vc1[k])) >> 1)
                             : div3({1'b0, vc0[k], 1'b0} + 10'(vc1[k]));
        default: vr[k] = transp ? 8'd0 : div3(10'(vc0[k]) + {1'b0, vc1[k], 1'b0});
      endcase
    end
    ch_a = chan_entry(job_i.lo[7:0], job_i.lo[15:8], ai);
    ch_g = chan_entry(job_i.hi[7:0], job_i.hi[15:8], gi);
    if (job_i.fmt == FMT_BC5) begin
      r1 = ch_a; g1 = ch_g; b1 = 8'd0; a1 = 8'd255;
    end else begin
      r1 = vr[0]; g1 = vr[1]; b1 = vr[2];
      a1 = (job_i.fmt == FMT_BC3) ? ch_a : ((transp && ci == 2'd3) ? 8'd0 : 8'd255);
    end
  end

  out_word_t s1_q;
  logic      s1_v_q, s1_bc5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else s1_v_q <= go;
  end

  always_ff @(posedge clk_i) begin
    s1_q.pixel_x <= job_i.base_x + 14'(t[1:0]);
    s1_q.pixel_y <= job_i.base_y + 14'(t[3:2]);
    s1_q.red <= r1; s1_q.green <= g1; s1_q.blue <= b1; s1_q.alpha <= a1;
    s1_q.last <= rest == 16'd0;
    s1_bc5_q <= job_i.fmt == FMT_BC5;
  end

  // stage 2: squared terms of the normal
  logic signed [8:0] dr, dg;
  logic [15:0] sq_r, sq_g;
  assign dr = $signed({s1_q.red, 1'b0}) - 9'sd255;
  assign dg = $signed({s1_q.green, 1'b0}) - 9'sd255;
  assign sq_r = 16'($unsigned(18'(dr) * 18'(dr)));
  assign sq_g = 16'($unsigned(18'(dg) * 18'(dg)));

  out_word_t s2_q;
  logic      s2_v_q, s2_bc5_q;
  logic [16:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s1_q;
    s2_bc5_q <= s1_bc5_q;
    sum_q <= 17'(sq_r) + 17'(sq_g);
  end

  logic [15:0] sv;
  assign sv = (sum_q >= 17'd65025) ? 16'd0 : 16'(17'd65025 - sum_q);

  // delay line matched to the root pipeline
  out_word_t dl_q [Lat-2];
  logic      dv_q [Lat-2];
  logic      db_q [Lat-2];
  logic [7:0] root;

  bctd_isqrt u_sqrt (.clk_i(clk_i), .v_i(sv), .r_o(root));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Lat-2; k++) dv_q[k] <= 1'b0;
    end else begin
      dv_q[0] <= s2_v_q;
      for (int k = 1; k < Lat-2; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= s2_q;
    db_q[0] <= s2_bc5_q;
    for (int k = 1; k < Lat-2; k++) begin
      dl_q[k] <= dl_q[k-1];
      db_q[k] <= db_q[k-1];
    end
  end

  always_comb begin
    word_o = dl_q[Lat-3];
    if (db_q[Lat-3]) word_o.blue = 8'((9'(root) + 9'd255) >> 1);
  end
  assign done_o = dv_q[Lat-3];

`ifndef NO_ASSERTIONS
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (rest == 16'd0)) else $error("pop before block finished");
  a_go_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> cur != 16'd0) else $error("empty texel mask in work");
  a_act_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> left_q != 16'd0) else $error("active with nothing left");
`endif

endmodule

// ----- hdl/bc_texture_block_decoder.sv -----
// top level of the bc1/bc3/bc5 block decoder
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------
//  block in | start_i, busy_o, in_i          | start_i && !busy_o
//  pixel out| valid_o, out_o                 | valid_o, one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i| cfg_we_i
//
// one pixel leaves per cycle while a block is queued, one per in-bounds texel
// (up to 16; a block with none in bounds is dropped at the front)
// the back end's texel walk sets the pixel rate
// an accepted block reaches the output through the queue, stages 1 and 2 and the root pipe
// a two-word queue lets a new block be taken while the back end works
// reset empties the queue, clears the walk state and valid bits, and sets the config to 4x4 bc1
// the receiver cannot stall: pixels stream out as produced
module bc_texture_block_decoder #(
  parameter int unsigned MAX_IMAGE_SIZE = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  bctd_pkg::in_word_t             in_i,
  output logic                           valid_o,
  output bctd_pkg::out_word_t            out_o,
  input  logic                           cfg_we_i,
  input  logic [bctd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bctd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bctd_pkg::*;

  logic [14:0] width_q, height_q;
  fmt_e        fmt_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 15'd4;
      height_q <= 15'd4;
      fmt_q    <= FMT_BC1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_FORMAT: fmt_q    <= fmt_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  logic    push, pop;
  job_t    job_in, job_out;
  q_stat_t stat;

  bctd_front #(.MaxImageSize(MAX_IMAGE_SIZE)) u_front (
    .clk_i, .rst_ni, .start_i, .in_i,
    .width_i(width_q), .height_i(height_q), .fmt_i(fmt_q),
    .stat_i(stat), .busy_o, .push_o(push), .job_o(job_in)
  );

  bctd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in),
    .pop_i(pop), .job_o(job_out), .stat_o(stat)
  );

  bctd_back u_back (
    .clk_i, .rst_ni, .job_i(job_out), .stat_i(stat),
    .pop_o(pop), .done_o(valid_o), .word_o(out_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !push) else $error("push while busy");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty) else $error("pop from empty queue");
  a_fmt_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> fmt_q != FMT_NONE) else $error("unused format pushed");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the bc1/bc3/bc5 texture block decoder
`timescale 1ns / 1ps

module tb_top;
  import bctd_pkg::*;

  localparam int unsigned MaxSize = 16384;
  localparam int unsigned SettleCycles = 80;    // root pipe plus two queued blocks
  localparam int unsigned CycleLimit = 400000;

  typedef int colour_pal_t[4][4];
  typedef int level_pal_t[8];

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  in_word_t    in_i;
  logic        valid_o;
  out_word_t   out_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [14:0] cfg_data_i;

  // shadow copy of the decoder registers
  logic [14:0] img_w;
  logic [14:0] img_h;
  fmt_e        img_fmt;

  out_word_t   pixel_q[$];   // expected pixels, oldest first
  int          errors;
  int          cycle_count;
  int          idle_pct;     // sender idle chance in percent

  bc_texture_block_decoder #(.MAX_IMAGE_SIZE(MaxSize)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .in_i(in_i),
    .valid_o(valid_o), .out_o(out_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // 565 expansion and four-colour palette
  function automatic colour_pal_t colour_palette(logic [63:0] blk, bit transp);
    colour_pal_t p;
    int c [2];
    int k;
    c[0] = int'(blk[15:0]);
    c[1] = int'(blk[31:16]);
    for (k = 0; k < 2; k++) begin
      p[k][0] = (((c[k] >> 11) & 'h1f) * 527 + 23) >> 6;
      p[k][1] = (((c[k] >> 5) & 'h3f) * 259 + 33) >> 6;
      p[k][2] = ((c[k] & 'h1f) * 527 + 23) >> 6;
      p[k][3] = 255;
    end
    for (k = 0; k < 3; k++) begin
      if (!transp || c[0] > c[1]) begin
        p[2][k] = (2 * p[0][k] + p[1][k]) / 3;
        p[3][k] = (p[0][k] + 2 * p[1][k]) / 3;
      end else begin
        p[2][k] = (p[0][k] + p[1][k]) / 2;
        p[3][k] = 0;
      end
    end
    p[2][3] = 255;
    p[3][3] = (!transp || c[0] > c[1]) ? 255 : 0;
    return p;
  endfunction

  // eight- or six-level single channel palette
  function automatic level_pal_t level_palette(logic [63:0] blk);
    level_pal_t p;
    int e0;
    int e1;
    int i;
    e0 = int'(blk[7:0]);
    e1 = int'(blk[15:8]);
    p[0] = e0;
    p[1] = e1;
    for (i = 2; i < 8; i++) begin
      if (e0 > e1) p[i] = ((8 - i) * e0 + (i - 1) * e1) / 7;
      else if (i < 6) p[i] = ((6 - i) * e0 + (i - 1) * e1) / 5;
      else p[i] = (i == 6) ? 0 : 255;
    end
    return p;
  endfunction

  // normal map z from red and green, fixed point
  function automatic int normal_blue(int r, int g);
    int dr;
    int dg;
    int s;
    int q;
    dr = 2 * r - 255;
    dg = 2 * g - 255;
    s = 65025 - dr * dr - dg * dg;
    if (s < 0) s = 0;
    q = 0;
    while ((q + 1) * (q + 1) <= s) q++;
    return (q + 255) >> 1;
  endfunction

  // expected pixels of one accepted block, appended to pixel_q
  function automatic void predict_pixels(in_word_t b);
    colour_pal_t cp;
    level_pal_t  ap;
    level_pal_t  gp;
    out_word_t   px;
    out_word_t   blk_q[$];
    int w;
    int h;
    int t;
    int x;
    int y;
    int ci;
    int ai;
    int gi;
    w = (img_w > MaxSize) ? MaxSize : int'(img_w);
    h = (img_h > MaxSize) ? MaxSize : int'(img_h);
    if (img_fmt == FMT_NONE) return;
    cp = colour_palette((img_fmt == FMT_BC1) ? b.block_low : b.block_high, img_fmt == FMT_BC1);
    ap = level_palette(b.block_low);
    gp = level_palette(b.block_high);
    for (t = 0; t < 16; t++) begin
      x = int'(b.block_col) * 4 + (t & 3);
      y = int'(b.block_row) * 4 + (t >> 2);
      if (x >= w || y >= h) continue;
      px = '0;
      px.pixel_x = x[13:0];
      px.pixel_y = y[13:0];
      ai = int'((b.block_low >> (16 + 3 * t)) & 64'h7);
      gi = int'((b.block_high >> (16 + 3 * t)) & 64'h7);
      if (img_fmt == FMT_BC5) begin
        px.red = 8'(ap[ai]);
        px.green = 8'(gp[gi]);
        px.blue = 8'(normal_blue(ap[ai], gp[gi]));
        px.alpha = 8'd255;
      end else begin
        ci = int'((((img_fmt == FMT_BC1) ? b.block_low : b.block_high) >> (32 + 2 * t))
                  & 64'h3);
        px.red = 8'(cp[ci][0]);
        px.green = 8'(cp[ci][1]);
        px.blue = 8'(cp[ci][2]);
        px.alpha = 8'((img_fmt == FMT_BC1) ? cp[ci][3] : ap[ai]);
      end
      blk_q.push_back(px);
    end
    if (blk_q.size() > 0) blk_q[blk_q.size() - 1].last = 1'b1;
    foreach (blk_q[i]) pixel_q.push_back(blk_q[i]);
  endfunction

  task automatic report(string name, int e, int a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // pixel checker: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pixel_q.size() == 0) begin
        $display("%0t unexpected pixel: expected none actual %p", $time, out_o);
        errors++;
      end else begin
        report("pixel_x", pixel_q[0].pixel_x, out_o.pixel_x);
        report("pixel_y", pixel_q[0].pixel_y, out_o.pixel_y);
        report("red", pixel_q[0].red, out_o.red);
        report("green", pixel_q[0].green, out_o.green);
        report("blue", pixel_q[0].blue, out_o.blue);
        report("alpha", pixel_q[0].alpha, out_o.alpha);
        report("last", pixel_q[0].last, out_o.last);
        void'(pixel_q.pop_front());
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one block word: held until accepted, then an optional idle gap
  task automatic send_block(in_word_t b);
    int gap;
    @(negedge clk_i);
    start_i = 1'b1;
    in_i = b;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    predict_pixels(b);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 24);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // stop sending and let the decoder go fully idle
  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [14:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_WIDTH:  img_w = data;
      CFG_HEIGHT: img_h = data;
      CFG_FORMAT: img_fmt = fmt_e'(data[1:0]);
      default: ;
    endcase
  endtask

  task automatic set_image(int w, int h, fmt_e f);
    write_reg(CFG_WIDTH, w[14:0]);
    write_reg(CFG_HEIGHT, h[14:0]);
    write_reg(CFG_FORMAT, 15'(f));
  endtask

  function automatic in_word_t rand_block(int col, int row);
    in_word_t b;
    b.block_col = col[11:0];
    b.block_row = row[11:0];
    b.block_low = {$urandom, $urandom};
    b.block_high = {$urandom, $urandom};
    return b;
  endfunction

  function automatic in_word_t fixed_block(int col, int row, logic [63:0] lo, logic [63:0] hi);
    in_word_t b;
    b.block_col = col[11:0];
    b.block_row = row[11:0];
    b.block_low = lo;
    b.block_high = hi;
    return b;
  endfunction

  // reset values, then each format at its end points and ordering modes
  task automatic test_formats;
    idle_pct = 0;
    send_block(fixed_block(0, 0, 64'h0, 64'h0));          // reset: bc1 4x4
    send_block(fixed_block(0, 0, '1, '1));                // c0 == c1, transparent mode
    send_block(fixed_block(0, 0, 64'h1b1b_e4e4_0000_ffff, 64'h0)); // four opaque colours
    send_block(fixed_block(0, 0, 64'he4e4_1b1b_ffff_0000, 64'h0)); // average plus black
    write_reg(CFG_FORMAT, 15'(FMT_BC3));
    send_block(fixed_block(0, 0, 64'hfac6_88fa_c688_00ff, 64'h1b1b_e4e4_0000_ffff));
    send_block(fixed_block(0, 0, 64'h0539_77a0_5397_ff00, 64'h1b1b_e4e4_ffff_0000));
    send_block(fixed_block(0, 0, '1, '1));
    write_reg(CFG_FORMAT, 15'(FMT_BC5));
    send_block(fixed_block(0, 0, 64'hfac6_88fa_c688_00ff, 64'h0539_77a0_5397_ff00));
    send_block(fixed_block(0, 0, 64'h0000_0000_0000_8080, 64'h0000_0000_0000_8080));
    send_block(fixed_block(0, 0, '0, '1));
    write_reg(CFG_FORMAT, 15'(FMT_NONE));                 // unused code: block ignored
    send_block(rand_block(0, 0));
    write_reg(CFG_NONE, 15'h7fff);                        // index past the list: ignored
  endtask

  // clipping: partial edges, outside blocks, zero and oversized images
  task automatic test_clipping;
    idle_pct = 0;
    set_image(6, 7, FMT_BC1);
    send_block(rand_block(1, 1));                         // partial edge block
    send_block(rand_block(2, 0));                         // wholly outside
    send_block(rand_block(0, 1));
    set_image(1, 1, FMT_BC3);
    send_block(rand_block(0, 0));                         // one texel
    set_image(0, 5, FMT_BC1);
    send_block(rand_block(0, 0));                         // zero width
    set_image(5, 0, FMT_BC5);
    send_block(rand_block(0, 0));                         // zero height
    set_image(32767, 32767, FMT_BC1);                     // saturated to max size
    send_block(rand_block(4095, 4095));
    send_block(rand_block(0, 4095));
    set_image(16383, 16384, FMT_BC5);
    send_block(rand_block(4095, 4095));
  endtask

  // random blocks over several image settings and idle mixes
  task automatic test_random;
    int ph;
    int n;
    int w;
    int h;
    int col;
    int row;
    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 31;
        default: idle_pct = 46;
      endcase
      if (ph % 3 == 2) begin
        w = $urandom_range(1, 32767);
        h = $urandom_range(1, 32767);
      end else begin
        w = $urandom_range(1, 14);
        h = $urandom_range(1, 14);
      end
      set_image(w, h, fmt_e'(ph % 3));
      if (ph == 7) write_reg(CFG_FORMAT, 15'($urandom_range(0, 3)));
      for (n = 0; n < 13; n++) begin
        if (w > 4096 * 4) col = $urandom_range(0, 4095);
        else col = $urandom_range(0, (w + 3) / 4 + (($urandom_range(0, 9) == 0) ? 1 : 0));
        if (h > 4096 * 4) row = $urandom_range(0, 4095);
        else row = $urandom_range(0, (h + 3) / 4 + (($urandom_range(0, 9) == 0) ? 1 : 0));
        if (col > 4095) col = 4095;
        if (row > 4095) row = 4095;
        send_block(rand_block(col, row));
      end
      // in phase 5, pause until every pixel is out before going on
      if (ph == 5) begin
        @(negedge clk_i);
        start_i = 1'b0;
        wait (pixel_q.size() == 0);
      end
    end
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    idle_pct = 0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_WIDTH;
    cfg_data_i = '0;
    img_w = 15'd4;
    img_h = 15'd4;
    img_fmt = FMT_BC1;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_formats();
    test_clipping();
    test_random();
    drain();

    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bctd_pkg.sv
hdl/bctd_front.sv
hdl/bctd_queue.sv
hdl/bctd_isqrt.sv
hdl/bctd_back.sv
hdl/bc_texture_block_decoder.sv
tb/tb_top.sv
